// File: rtl/lfp_pkg.sv
// ----------------------------------------------------------------------------
// lfp_pkg
// Shared constants, register indexes and the CRC-8 byte update for the
// lidar frame parser.
// ----------------------------------------------------------------------------
package lfp_pkg;

    localparam int PTS_PER_FRAME_DEF = 12;
    localparam int PTS_BEGIN         = 6;
    localparam int TAIL_BYTES        = 4;
    localparam int POINT_IDX_W       = 4;

    localparam logic [7:0] CRC_POLY   = 8'h4D;
    localparam logic [7:0] HDR_RESET  = 8'd84;
    localparam logic [7:0] LEN_RESET  = 8'd44;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = CFG_IDX_W'(1);

    // msb-first crc-8, no reflection, no final xor
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/lfp_rx_if.sv
// ----------------------------------------------------------------------------
// lfp_rx_if
// Byte stream channel into the frame parser.
// ----------------------------------------------------------------------------
interface lfp_rx_if;

    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);

endinterface

// File: rtl/lfp_pt_if.sv
// ----------------------------------------------------------------------------
// lfp_pt_if
// Point channel out of the frame parser, one item per frame point.
// ----------------------------------------------------------------------------
interface lfp_pt_if
    import lfp_pkg::*;
;

    logic                   valid;
    logic                   ready;
    logic [POINT_IDX_W-1:0] point_index;
    logic [15:0]            distance;
    logic [7:0]             confidence;
    logic [15:0]            first_angle;
    logic [15:0]            last_angle;
    logic [15:0]            rotation_speed;
    logic [15:0]            time_stamp;
    logic                   last_point;

    modport source (
        output valid, output point_index, output distance, output confidence,
        output first_angle, output last_angle, output rotation_speed,
        output time_stamp, output last_point, input ready
    );
    modport sink (
        input valid, input point_index, input distance, input confidence,
        input first_angle, input last_angle, input rotation_speed,
        input time_stamp, input last_point, output ready
    );

endinterface

// File: rtl/lidar_frame_parser_crc8_top.sv
// ----------------------------------------------------------------------------
// lidar_frame_parser_crc8_top
// Lidar frame parser: header and length check, field capture and CRC-8
// check over a byte stream, with one output item per frame point.
// ----------------------------------------------------------------------------
// The rx channel takes one byte per cycle. The running CRC is updated by a
// single bitwise step per byte, so parsing never stalls on its own. When the
// CRC byte of a frame matches, the frame's points are copied into an output
// shift line and delivered as POINTS_PER_FRAME consecutive items, one per
// cycle while points.ready is high; the first point is valid in the cycle
// after the CRC byte is taken, and the next frame is parsed meanwhile. rx
// holds ready low only on the CRC byte of a frame while points of the
// previous frame are still waiting to be taken. There is no clearing pass
// after reset; the point and field stores hold unknown data until written.
module lidar_frame_parser_crc8_top
    import lfp_pkg::*;
#(
    parameter int POINTS_PER_FRAME = PTS_PER_FRAME_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_wdata,
    lfp_rx_if.sink               rx,
    lfp_pt_if.source             points
);

    localparam int PTS_END = PTS_BEGIN + 3 * POINTS_PER_FRAME;
    localparam int CRC_POS = PTS_END + TAIL_BYTES;
    localparam int POS_W   = $clog2(CRC_POS + 1);
    localparam int IDX_W   = (POINTS_PER_FRAME > 1) ? $clog2(POINTS_PER_FRAME) : 1;
    localparam int CNT_W   = $clog2(POINTS_PER_FRAME + 1);

    localparam logic [POS_W-1:0] POS_HDR   = POS_W'(0);
    localparam logic [POS_W-1:0] POS_LEN   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_SPD_L = POS_W'(2);
    localparam logic [POS_W-1:0] POS_SPD_H = POS_W'(3);
    localparam logic [POS_W-1:0] POS_STA_L = POS_W'(4);
    localparam logic [POS_W-1:0] POS_STA_H = POS_W'(5);
    localparam logic [POS_W-1:0] POS_PTS   = POS_W'(PTS_BEGIN);
    localparam logic [POS_W-1:0] POS_END_L = POS_W'(PTS_END);
    localparam logic [POS_W-1:0] POS_END_H = POS_W'(PTS_END + 1);
    localparam logic [POS_W-1:0] POS_TS_L  = POS_W'(PTS_END + 2);
    localparam logic [POS_W-1:0] POS_TS_H  = POS_W'(PTS_END + 3);
    localparam logic [POS_W-1:0] POS_CRC   = POS_W'(CRC_POS);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(POINTS_PER_FRAME);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    typedef enum logic [1:0] {PH_DIST_LO, PH_DIST_HI, PH_CONF} phase_t;

    typedef struct packed {
        logic spd_lo;
        logic spd_hi;
        logic sta_lo;
        logic sta_hi;
        logic dist_lo;
        logic dist_hi;
        logic conf;
        logic end_lo;
        logic end_hi;
        logic ts_lo;
        logic ts_hi;
        logic snap;
    } wr_t;

    // control state
    logic [7:0]       hdr_reg, hdr_next;
    logic [7:0]       len_reg, len_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       crc_reg, crc_next;
    logic [IDX_W-1:0] pc_reg, pc_next;
    phase_t           ph_reg, ph_next;
    logic [CNT_W-1:0] out_cnt_reg, out_cnt_next;
    logic [IDX_W-1:0] out_k_reg, out_k_next;

    // frame stores
    logic [15:0] dist_reg [POINTS_PER_FRAME];
    logic [7:0]  conf_reg [POINTS_PER_FRAME];
    logic [15:0] spd_reg;
    logic [15:0] sta_reg;
    logic [15:0] end_reg;
    logic [15:0] ts_reg;

    // output shift line
    logic [15:0] buf_dist_reg [POINTS_PER_FRAME];
    logic [7:0]  buf_conf_reg [POINTS_PER_FRAME];
    logic [15:0] buf_spd_reg;
    logic [15:0] buf_sta_reg;
    logic [15:0] buf_end_reg;
    logic [15:0] buf_ts_reg;

    logic       rx_take;
    logic       pt_take;
    logic       is_pts;
    logic [7:0] b;
    wr_t        wr;

    assign b       = rx.rx_byte;
    assign rx.ready = (pos_reg != POS_CRC) || (out_cnt_reg == '0);
    assign rx_take = rx.valid && rx.ready;
    assign pt_take = points.valid && points.ready;
    assign is_pts  = (pos_reg >= POS_PTS) && (pos_reg < POS_END_L);

    always_comb
    begin
        hdr_next = hdr_reg;
        len_next = len_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEADER: hdr_next = cfg_wdata;
                CFG_LENGTH: len_next = cfg_wdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        crc_next = crc_reg;
        pc_next  = pc_reg;
        ph_next  = ph_reg;
        wr       = '0;
        if (rx_take)
        begin
            pos_next = pos_reg + POS_W'(1);
            crc_next = crc8_step(crc_reg, b);
            if (pos_reg == POS_CRC)
            begin
                wr.snap = (b == crc_reg);
                pos_next = '0;
                crc_next = '0;
                pc_next  = '0;
                ph_next  = PH_DIST_LO;
            end
            else if (is_pts)
            begin
                case (ph_reg)
                    PH_DIST_LO:
                    begin
                        wr.dist_lo = 1'b1;
                        ph_next    = PH_DIST_HI;
                    end
                    PH_DIST_HI:
                    begin
                        wr.dist_hi = 1'b1;
                        ph_next    = PH_CONF;
                    end
                    default:
                    begin
                        wr.conf = 1'b1;
                        ph_next = PH_DIST_LO;
                        pc_next = pc_reg + IDX_W'(1);
                    end
                endcase
            end
            else
            begin
                case (pos_reg)
                    POS_HDR:
                    begin
                        if (b != hdr_reg)
                        begin
                            pos_next = '0;
                            crc_next = '0;
                        end
                    end
                    POS_LEN:
                    begin
                        if (b != len_reg)
                        begin
                            pos_next = '0;
                            crc_next = '0;
                        end
                    end
                    POS_SPD_L: wr.spd_lo = 1'b1;
                    POS_SPD_H: wr.spd_hi = 1'b1;
                    POS_STA_L: wr.sta_lo = 1'b1;
                    POS_STA_H: wr.sta_hi = 1'b1;
                    POS_END_L: wr.end_lo = 1'b1;
                    POS_END_H: wr.end_hi = 1'b1;
                    POS_TS_L:  wr.ts_lo  = 1'b1;
                    POS_TS_H:  wr.ts_hi  = 1'b1;
                    default:
                    begin
                        pos_next = '0;
                        crc_next = '0;
                        pc_next  = '0;
                        ph_next  = PH_DIST_LO;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        out_k_next   = out_k_reg;
        if (wr.snap)
        begin
            out_cnt_next = CNT_FULL;
            out_k_next   = '0;
        end
        else if (pt_take)
        begin
            out_cnt_next = out_cnt_reg - CNT_ONE;
            out_k_next   = out_k_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg     <= HDR_RESET;
            len_reg     <= LEN_RESET;
            pos_reg     <= '0;
            crc_reg     <= '0;
            pc_reg      <= '0;
            ph_reg      <= PH_DIST_LO;
            out_cnt_reg <= '0;
            out_k_reg   <= '0;
        end
        else
        begin
            hdr_reg     <= hdr_next;
            len_reg     <= len_next;
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            pc_reg      <= pc_next;
            ph_reg      <= ph_next;
            out_cnt_reg <= out_cnt_next;
            out_k_reg   <= out_k_next;
        end
    end

    // frame stores, written byte lane by byte lane
    always_ff @(posedge clk)
    begin
        if (wr.spd_lo)  spd_reg[7:0]  <= b;
        if (wr.spd_hi)  spd_reg[15:8] <= b;
        if (wr.sta_lo)  sta_reg[7:0]  <= b;
        if (wr.sta_hi)  sta_reg[15:8] <= b;
        if (wr.end_lo)  end_reg[7:0]  <= b;
        if (wr.end_hi)  end_reg[15:8] <= b;
        if (wr.ts_lo)   ts_reg[7:0]   <= b;
        if (wr.ts_hi)   ts_reg[15:8]  <= b;
        if (wr.dist_lo) dist_reg[pc_reg][7:0]  <= b;
        if (wr.dist_hi) dist_reg[pc_reg][15:8] <= b;
        if (wr.conf)    conf_reg[pc_reg]       <= b;
    end

    // output shift line, head entry drives the point channel
    always_ff @(posedge clk)
    begin
        if (wr.snap)
        begin
            buf_dist_reg <= dist_reg;
            buf_conf_reg <= conf_reg;
            buf_spd_reg  <= spd_reg;
            buf_sta_reg  <= sta_reg;
            buf_end_reg  <= end_reg;
            buf_ts_reg   <= ts_reg;
        end
        else if (pt_take)
        begin
            for (int i = 0; i < POINTS_PER_FRAME - 1; i++)
            begin
                buf_dist_reg[i] <= buf_dist_reg[i+1];
                buf_conf_reg[i] <= buf_conf_reg[i+1];
            end
        end
    end

    assign points.valid          = (out_cnt_reg != '0);
    assign points.point_index    = POINT_IDX_W'(out_k_reg);
    assign points.distance       = buf_dist_reg[0];
    assign points.confidence     = buf_conf_reg[0];
    assign points.first_angle    = buf_sta_reg;
    assign points.last_angle     = buf_end_reg;
    assign points.rotation_speed = buf_spd_reg;
    assign points.time_stamp     = buf_ts_reg;
    assign points.last_point     = (out_cnt_reg == CNT_ONE);

    // a good frame is never loaded over points still pending
    a_snap_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_take && (pos_reg == POS_CRC)) |-> (out_cnt_reg == '0))
        else $error("frame loaded while points pending");

    // the last point of a frame closes the burst
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (pt_take && points.last_point) |=> !points.valid)
        else $error("points still valid after last point");

    // frame position stays within the frame
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_CRC)
        else $error("frame position out of range");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the lidar frame parser with byte streams: stray bytes, broken
// headers and lengths, a frame with a bad CRC and good frames with random
// payloads, under two header and length settings.
// A frame decoder kept in step with every accepted byte predicts the points,
// and the monitor checks each point item against the oldest prediction.
// Both channels idle in random bursts, and the point side holds off once for
// a long stretch so the parser backs up on the byte side.
// ----------------------------------------------------------------------------
module tb_top
    import lfp_pkg::*;
;

    localparam int NPTS        = PTS_PER_FRAME_DEF;
    localparam int PTS_END     = PTS_BEGIN + 3 * NPTS;
    localparam int CRC_AT      = PTS_END + TAIL_BYTES;
    localparam int FRAME_BYTES = CRC_AT + 1;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 10;
    localparam int CYCLE_LIMIT = 150000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = CFG_IDX_W'(3);

    typedef enum int {FILL_RAND, FILL_ZERO, FILL_ONES} fill_e;

    typedef struct packed {
        logic [POINT_IDX_W-1:0] index;
        logic [15:0]            dist_raw;
        logic [7:0]             conf;
        logic [15:0]            ang_start;
        logic [15:0]            ang_end;
        logic [15:0]            speed;
        logic [15:0]            tstamp;
        logic                   last;
    } point_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_wdata;

    lfp_rx_if rx ();
    lfp_pt_if points ();

    lidar_frame_parser_crc8_top #(
        .POINTS_PER_FRAME (NPTS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .rx        (rx),
        .points    (points)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // frame decoder state
    logic [7:0]  hdr_val = HDR_RESET;
    logic [7:0]  len_val = LEN_RESET;
    int          fr_pos = 0;
    logic [7:0]  fr_crc = 8'h00;
    int          pt_cnt = 0;
    logic [15:0] pt_dist [NPTS];
    logic [7:0]  pt_conf [NPTS];
    logic [15:0] fr_speed;
    logic [15:0] fr_ang_start;
    logic [15:0] fr_ang_end;
    logic [15:0] fr_tstamp;

    point_t      pending_points [$];
    logic [7:0]  byte_q [$];
    int          bytes_pushed = 0;
    int          bytes_taken = 0;
    int          errors = 0;
    int          cycle_cnt;

    logic        rx_took = 1'b0;
    int          rx_gap = 0;
    int          pt_gap = 0;
    int          idle_odds = 0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;

    function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = crc ^ b;
        repeat (8)
        begin
            fb = r[7];
            r = r << 1;
            if (fb)
            begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    task automatic go_hunt();
        fr_pos = 0;
        fr_crc = 8'h00;
        pt_cnt = 0;
    endtask

    task automatic decode_byte(input logic [7:0] b);
        point_t p;
        int     ph;
        if (fr_pos == CRC_AT)
        begin
            if (b == fr_crc)
            begin
                for (int k = 0; k < NPTS; k++)
                begin
                    p.index     = POINT_IDX_W'(k);
                    p.dist_raw  = pt_dist[k];
                    p.conf      = pt_conf[k];
                    p.ang_start = fr_ang_start;
                    p.ang_end   = fr_ang_end;
                    p.speed     = fr_speed;
                    p.tstamp    = fr_tstamp;
                    p.last      = (k == NPTS - 1);
                    pending_points.push_back(p);
                end
            end
            go_hunt();
            return;
        end
        if ((fr_pos == 0 && b != hdr_val) || (fr_pos == 1 && b != len_val))
        begin
            go_hunt();
            return;
        end
        if (fr_pos == 2)
            fr_speed = {8'h00, b};
        else if (fr_pos == 3)
            fr_speed[15:8] = b;
        else if (fr_pos == 4)
            fr_ang_start = {8'h00, b};
        else if (fr_pos == 5)
            fr_ang_start[15:8] = b;
        else if (fr_pos >= PTS_BEGIN && fr_pos < PTS_END)
        begin
            ph = (fr_pos - PTS_BEGIN) % 3;
            if (ph == 0 && pt_cnt < NPTS)
                pt_dist[pt_cnt] = {8'h00, b};
            else if (ph == 1 && pt_cnt < NPTS)
                pt_dist[pt_cnt][15:8] = b;
            else if (ph == 2)
            begin
                if (pt_cnt < NPTS)
                    pt_conf[pt_cnt] = b;
                pt_cnt++;
            end
        end
        else if (fr_pos == PTS_END)
            fr_ang_end = {8'h00, b};
        else if (fr_pos == PTS_END + 1)
            fr_ang_end[15:8] = b;
        else if (fr_pos == PTS_END + 2)
            fr_tstamp = {8'h00, b};
        else if (fr_pos == PTS_END + 3)
            fr_tstamp[15:8] = b;
        fr_crc = crc_next(fr_crc, b);
        fr_pos++;
    endtask

    task automatic check_point(input point_t got);
        point_t want;
        if (pending_points.size() == 0)
        begin
            $error("point item with none expected: index %0d", got.index);
            errors++;
            return;
        end
        want = pending_points.pop_front();
        if (got.index !== want.index)
        begin
            $error("point_index expected %0d got %0d", want.index, got.index);
            errors++;
        end
        if (got.dist_raw !== want.dist_raw)
        begin
            $error("distance expected %h got %h", want.dist_raw, got.dist_raw);
            errors++;
        end
        if (got.conf !== want.conf)
        begin
            $error("confidence expected %h got %h", want.conf, got.conf);
            errors++;
        end
        if (got.ang_start !== want.ang_start)
        begin
            $error("first_angle expected %h got %h", want.ang_start, got.ang_start);
            errors++;
        end
        if (got.ang_end !== want.ang_end)
        begin
            $error("last_angle expected %h got %h", want.ang_end, got.ang_end);
            errors++;
        end
        if (got.speed !== want.speed)
        begin
            $error("rotation_speed expected %h got %h", want.speed, got.speed);
            errors++;
        end
        if (got.tstamp !== want.tstamp)
        begin
            $error("time_stamp expected %h got %h", want.tstamp, got.tstamp);
            errors++;
        end
        if (got.last !== want.last)
        begin
            $error("last_point expected %b got %b", want.last, got.last);
            errors++;
        end
    endtask

    // monitor
    always @(posedge clk)
    begin
        point_t got;
        if (!rst_n)
        begin
            rx_took <= 1'b0;
        end
        else
        begin
            rx_took <= rx.valid && rx.ready;
            if (cfg_we)
            begin
                if (cfg_index == CFG_HEADER)
                    hdr_val = cfg_wdata;
                else if (cfg_index == CFG_LENGTH)
                    len_val = cfg_wdata;
            end
            if (rx.valid && rx.ready)
            begin
                decode_byte(rx.rx_byte);
                bytes_taken++;
            end
            if (points.valid && points.ready)
            begin
                got.index     = points.point_index;
                got.dist_raw  = points.distance;
                got.conf      = points.confidence;
                got.ang_start = points.first_angle;
                got.ang_end   = points.last_angle;
                got.speed     = points.rotation_speed;
                got.tstamp    = points.time_stamp;
                got.last      = points.last_point;
                check_point(got);
            end
        end
    end

    // byte driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rx.valid   <= 1'b0;
            rx.rx_byte <= 8'h00;
            rx_gap     <= 0;
        end
        else if (!rx.valid || rx_took)
        begin
            if (rx_gap > 0)
            begin
                rx_gap   <= rx_gap - 1;
                rx.valid <= 1'b0;
            end
            else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            begin
                rx_gap   <= $urandom_range(0, 6);
                rx.valid <= 1'b0;
            end
            else if (byte_q.size() > 0)
            begin
                rx.valid   <= 1'b1;
                rx.rx_byte <= byte_q.pop_front();
            end
            else
            begin
                rx.valid <= 1'b0;
            end
        end
    end

    // long hold-off on the point side
    always @(negedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // point side ready
    always @(negedge clk)
    begin
        if (!rst_n || hold_left > 0)
        begin
            points.ready <= 1'b0;
        end
        else if (pt_gap > 0)
        begin
            pt_gap       <= pt_gap - 1;
            points.ready <= 1'b0;
        end
        else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            pt_gap       <= $urandom_range(0, 6);
            points.ready <= 1'b0;
        end
        else
        begin
            points.ready <= 1'b1;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        byte_q.push_back(b);
        bytes_pushed++;
    endtask

    task automatic queue_frame(input fill_e fill, input bit crc_good);
        logic [7:0] f [FRAME_BYTES];
        logic [7:0] c;
        c    = 8'h00;
        f[0] = hdr_val;
        f[1] = len_val;
        for (int i = 2; i < CRC_AT; i++)
        begin
            case (fill)
                FILL_ZERO: f[i] = 8'h00;
                FILL_ONES: f[i] = 8'hFF;
                default:   f[i] = 8'($urandom);
            endcase
        end
        for (int i = 0; i < CRC_AT; i++)
            c = crc_next(c, f[i]);
        f[CRC_AT] = crc_good ? c : c ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < FRAME_BYTES; i++)
            push_byte(f[i]);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic wait_drained();
        while (bytes_taken != bytes_pushed || pending_points.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = 8'h00;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_UNUSED_LO, 8'hFF);
        write_reg(CFG_UNUSED_HI, 8'h00);

        @(posedge clk);
        idle_odds = 6;
        push_byte(8'h00);
        push_byte(8'hFF);
        // bad length that equals the header value is not taken as a new header
        push_byte(hdr_val);
        push_byte(hdr_val);
        push_byte(len_val);
        push_byte(hdr_val);
        push_byte(8'hFF);
        push_byte(hdr_val);
        push_byte(8'h00);
        push_byte(8'h55);
        push_byte(8'hAA);
        wait_drained();

        write_reg(CFG_HEADER, 8'h00);
        write_reg(CFG_LENGTH, 8'hFF);
        @(posedge clk);
        hold_req = 1'b1;
        queue_frame(FILL_RAND, 1'b1);
        queue_frame(FILL_ONES, 1'b0);
        wait_drained();

        write_reg(CFG_HEADER, HDR_RESET);
        write_reg(CFG_LENGTH, LEN_RESET);
        @(posedge clk);
        idle_odds = 0;
        push_byte(hdr_val);
        push_byte(len_val ^ 8'($urandom_range(1, 255)));
        queue_frame(FILL_RAND, 1'b1);
        wait_drained();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
